>>> rtl/pli_pkg.sv
// Package for the positional list: widths, operation and status codes, cell control.
`default_nettype none

package pli_pkg;

    // Widths fixed by the request and result fields.
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 10;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 11;

    // Default number of entries in the list.
    localparam int CAPACITY_DEFAULT = 64;

    // Request operation codes; the two unused codes are rejected.
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DEL_POS   = 3'd5
    } op_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Command broadcast to every cell of the row.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } cell_cmd_t;

    // Control bundle from the list controller to the cells.
    typedef struct packed {
        cell_cmd_t          cmd;
        logic [LEN_W-1:0]   slot;
        logic [DATA_W-1:0]  data;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/pli_req_if.sv
// Request channel: operation, value and position with a valid/ready handshake.
`default_nettype none

interface pli_req_if;
    logic                                valid;
    logic                                ready;
    logic [pli_pkg::OP_W-1:0]            operation;
    logic signed [pli_pkg::DATA_W-1:0]   value;
    logic [pli_pkg::POS_W-1:0]           position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/pli_rsp_if.sv
// Result channel: status, length and removed value with a valid/ready handshake.
`default_nettype none

interface pli_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [pli_pkg::STAT_W-1:0]          status;
    logic [pli_pkg::LEN_W-1:0]           length;
    logic signed [pli_pkg::DATA_W-1:0]   removed_value;

    modport source (output valid, output status, output length, output removed_value,
                    input ready);
    modport sink   (input valid, input status, input length, input removed_value,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/pli_cell.sv
// One list cell: holds one stored value and shifts with its neighbors.
`default_nettype none

module pli_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                         clk,
    input  wire pli_pkg::cell_ctrl_t          ctrl,
    input  wire logic [pli_pkg::DATA_W-1:0]   left,
    input  wire logic [pli_pkg::DATA_W-1:0]   right,
    output logic [pli_pkg::DATA_W-1:0]        value,
    output logic [pli_pkg::DATA_W-1:0]        tap
);

    localparam logic [pli_pkg::LEN_W-1:0] IDX = pli_pkg::LEN_W'(INDEX);

    logic [pli_pkg::DATA_W-1:0] val_reg;
    logic [pli_pkg::DATA_W-1:0] val_next;
    logic [pli_pkg::DATA_W-1:0] tap_reg;
    logic [pli_pkg::DATA_W-1:0] tap_next;

    // Insert moves cells above the slot up by one; delete pulls cells from the slot down.
    // The tap gets the old slot value on a delete, zero on an insert, and holds otherwise.
    always_comb
    begin
        val_next = val_reg;
        tap_next = tap_reg;
        unique case (ctrl.cmd)
            pli_pkg::CELL_INS:
            begin
                tap_next = '0;
                if (IDX > ctrl.slot)
                begin
                    val_next = left;
                end
                else if (IDX == ctrl.slot)
                begin
                    val_next = ctrl.data;
                end
            end
            pli_pkg::CELL_DEL:
            begin
                tap_next = (IDX == ctrl.slot) ? val_reg : '0;
                if (IDX >= ctrl.slot)
                begin
                    val_next = right;
                end
            end
            pli_pkg::CELL_HOLD:
            begin
                val_next = val_reg;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        tap_reg <= tap_next;
    end

    assign value = val_reg;
    assign tap   = tap_reg;

endmodule

`default_nettype wire

>>> rtl/positional_list_insert_delete.sv
// Top level of the positional list: request checks, cell row and result register.
//
//  Channel | Dir | Fields                                  | Handshake
//  --------+-----+-----------------------------------------+------------
//  req     | in  | operation[2:0], value[31:0], position   | valid/ready
//  rsp     | out | status[1:0], length[10:0], removed_value| valid/ready
//
// Every request is applied to the cell row in the cycle it is accepted, so one
// request per cycle is taken while the result channel does not stall; its status and
// length go to stage one and then to the result register, from which it is transferred.
// The removed value is captured by a tap in each cell and combined by an OR over
// the row into the result register; it is used only for a completed delete. Reset
// clears the length and the handshake state; cell contents stay undefined until
// written. A stalled result holds the pipeline, and requests are refused only when
// both stages are full.
`default_nettype none

module positional_list_insert_delete #(
    parameter int CAPACITY = pli_pkg::CAPACITY_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pli_req_if.sink    req,
    pli_rsp_if.source  rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [pli_pkg::LEN_W-1:0] CAP_X = pli_pkg::LEN_W'(CAPACITY);
    localparam logic [pli_pkg::LEN_W-1:0] ONE_X = pli_pkg::LEN_W'(1);

    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    logic [pli_pkg::STAT_W-1:0]        s1_status_reg;
    logic [pli_pkg::STAT_W-1:0]        s1_status_next;
    logic [pli_pkg::LEN_W-1:0]         s1_length_reg;
    logic [pli_pkg::LEN_W-1:0]         s1_length_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [pli_pkg::STAT_W-1:0]        out_status_reg;
    logic [pli_pkg::STAT_W-1:0]        out_status_next;
    logic [pli_pkg::LEN_W-1:0]         out_length_reg;
    logic [pli_pkg::LEN_W-1:0]         out_length_next;
    logic [pli_pkg::DATA_W-1:0]        out_removed_reg;
    logic [pli_pkg::DATA_W-1:0]        out_removed_next;

    logic                              accept;
    logic                              s1_adv;
    logic [pli_pkg::LEN_W-1:0]         cnt_x;
    logic [pli_pkg::LEN_W-1:0]         pos_x;
    logic [pli_pkg::LEN_W-1:0]         pick;
    pli_pkg::status_t                  status;
    logic [CW-1:0]                     count_new;
    pli_pkg::cell_ctrl_t               ctrl;
    logic [pli_pkg::DATA_W-1:0]        tap_or;

    logic [pli_pkg::DATA_W-1:0]        cell_val [CAPACITY];
    logic [pli_pkg::DATA_W-1:0]        cell_tap [CAPACITY];

    // Handshake: stage one advances when the result register is free or drained.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    assign cnt_x = pli_pkg::LEN_W'(count_reg);
    assign pos_x = pli_pkg::LEN_W'(req.position);

    // Request check: status, target slot and the new length.
    always_comb
    begin
        pick      = '0;
        status    = pli_pkg::ST_RANGE;
        count_new = count_reg;
        ctrl.cmd  = pli_pkg::CELL_HOLD;
        ctrl.data = req.value;
        unique case (pli_pkg::op_t'(req.operation))
            pli_pkg::OP_INS_FRONT, pli_pkg::OP_INS_END, pli_pkg::OP_INS_POS:
            begin
                if (pli_pkg::op_t'(req.operation) == pli_pkg::OP_INS_FRONT)
                begin
                    pick = ONE_X;
                end
                else if (pli_pkg::op_t'(req.operation) == pli_pkg::OP_INS_END)
                begin
                    pick = cnt_x + ONE_X;
                end
                else
                begin
                    pick = pos_x;
                end
                if (cnt_x == CAP_X)
                begin
                    status = pli_pkg::ST_FULL;
                end
                else if ((pick == '0) || (pick > cnt_x + ONE_X))
                begin
                    status = pli_pkg::ST_RANGE;
                end
                else
                begin
                    status    = pli_pkg::ST_DONE;
                    count_new = CW'(cnt_x + ONE_X);
                    ctrl.cmd  = pli_pkg::CELL_INS;
                end
            end
            pli_pkg::OP_DEL_FRONT, pli_pkg::OP_DEL_END, pli_pkg::OP_DEL_POS:
            begin
                if (pli_pkg::op_t'(req.operation) == pli_pkg::OP_DEL_FRONT)
                begin
                    pick = ONE_X;
                end
                else if (pli_pkg::op_t'(req.operation) == pli_pkg::OP_DEL_END)
                begin
                    pick = cnt_x;
                end
                else
                begin
                    pick = pos_x;
                end
                if (cnt_x == '0)
                begin
                    status = pli_pkg::ST_EMPTY;
                end
                else if ((pick == '0) || (pick > cnt_x))
                begin
                    status = pli_pkg::ST_RANGE;
                end
                else
                begin
                    status    = pli_pkg::ST_DONE;
                    count_new = CW'(cnt_x - ONE_X);
                    ctrl.cmd  = pli_pkg::CELL_DEL;
                end
            end
            default:
            begin
                status = pli_pkg::ST_RANGE;
            end
        endcase
        ctrl.slot = pick - ONE_X;
        if (!accept)
        begin
            ctrl.cmd = pli_pkg::CELL_HOLD;
        end
    end

    // Row of cells; the end cells see their own value as the missing neighbor.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [pli_pkg::DATA_W-1:0] left_w;
        logic [pli_pkg::DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = cell_val[i];
        end
        else
        begin : g_inner_left
            assign left_w = cell_val[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = cell_val[i];
        end
        else
        begin : g_inner_right
            assign right_w = cell_val[i+1];
        end

        pli_cell #(
            .INDEX (i)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .left  (left_w),
            .right (right_w),
            .value (cell_val[i]),
            .tap   (cell_tap[i])
        );
    end

    // At most one tap is nonzero, so an OR over the row yields the removed value.
    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tap_or = tap_or | cell_tap[i];
        end
    end

    // Next values of the length, stage one and the result register.
    // A rejected request leaves the taps untouched, so its removed value is forced to zero.
    always_comb
    begin
        count_next       = accept ? count_new : count_reg;
        s1_valid_next    = accept || (s1_valid_reg && !s1_adv);
        s1_status_next   = accept ? status : s1_status_reg;
        s1_length_next   = accept ? pli_pkg::LEN_W'(count_new) : s1_length_reg;
        out_valid_next   = s1_adv || (out_valid_reg && !rsp.ready);
        out_status_next  = s1_adv ? s1_status_reg : out_status_reg;
        out_length_next  = s1_adv ? s1_length_reg : out_length_reg;
        out_removed_next = s1_adv ? ((s1_status_reg == pli_pkg::ST_DONE) ? tap_or : '0)
                                  : out_removed_reg;
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_status_reg   <= s1_status_next;
        s1_length_reg   <= s1_length_next;
        out_status_reg  <= out_status_next;
        out_length_reg  <= out_length_next;
        out_removed_reg <= out_removed_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.length        = out_length_reg;
    assign rsp.removed_value = out_removed_reg;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the positional list: request driver, result monitor, predictor.
`timescale 1ns / 100ps

module tb_top;
    import pli_pkg::*;

    localparam int LIST_DEPTH  = CAPACITY_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 700;
    localparam int REPORT_MAX  = 10;

    // Operation codes the block does not define; both must be rejected.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
        bit                       settle_first;
    } list_request_t;

    typedef struct {
        status_t                  status;
        logic [LEN_W-1:0]         length;
        logic signed [DATA_W-1:0] removed;
    } list_outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pli_req_if req_ch ();
    pli_rsp_if rsp_ch ();

    positional_list_insert_delete #(
        .CAPACITY (LIST_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Stimulus, predicted contents and expected results.
    list_request_t            pending_reqs[$];
    list_request_t            cur_req;
    list_outcome_t            expected_results[$];
    logic signed [DATA_W-1:0] list_contents[$];

    int gen_len     = 0;
    int stim_total  = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int n_errors    = 0;
    int peak_len    = 0;
    int cycle_count = 0;
    int status_hits[4] = '{0, 0, 0, 0};

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit is_insert(input logic [OP_W-1:0] op);
        return op == OP_INS_FRONT || op == OP_INS_END || op == OP_INS_POS;
    endfunction

    // The 1-based position that an operation acts on, given the current length.
    function automatic int slot_of(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                   input int len);
        case (op)
            OP_INS_FRONT, OP_DEL_FRONT: return 1;
            OP_INS_END:                 return len + 1;
            OP_DEL_END:                 return len;
            default:                    return int'(pos);
        endcase
    endfunction

    // Status of a request; the full and empty checks take priority over the position.
    function automatic status_t judge_request(input logic [OP_W-1:0] op,
                                              input logic [POS_W-1:0] pos, input int len);
        int p;
        p = slot_of(op, pos, len);
        if (is_insert(op))
        begin
            if (len >= LIST_DEPTH)
                return ST_FULL;
            if (p < 1 || p > len + 1)
                return ST_RANGE;
            return ST_DONE;
        end
        if (op == OP_DEL_FRONT || op == OP_DEL_END || op == OP_DEL_POS)
        begin
            if (len == 0)
                return ST_EMPTY;
            if (p < 1 || p > len)
                return ST_RANGE;
            return ST_DONE;
        end
        return ST_RANGE;
    endfunction

    // Apply one accepted request to the predicted list and return its result.
    function automatic list_outcome_t list_apply(input list_request_t rq);
        list_outcome_t res;
        int p;
        p = slot_of(rq.op, rq.position, list_contents.size());
        res.status  = judge_request(rq.op, rq.position, list_contents.size());
        res.removed = '0;
        if (res.status == ST_DONE)
        begin
            if (is_insert(rq.op))
                list_contents.insert(p - 1, rq.value);
            else
            begin
                res.removed = list_contents[p - 1];
                list_contents.delete(p - 1);
            end
        end
        res.length = LEN_W'(list_contents.size());
        if (list_contents.size() > peak_len)
            peak_len = list_contents.size();
        return res;
    endfunction

    // Queue a request and track the length it leaves, so positions can be aimed.
    task automatic queue_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v,
                                 input logic [POS_W-1:0] pos, input bit settle);
        list_request_t rq;
        rq.op           = op;
        rq.value        = v;
        rq.position     = pos;
        rq.settle_first = settle;
        pending_reqs.push_back(rq);
        if (judge_request(op, pos, gen_len) == ST_DONE)
            gen_len += is_insert(op) ? 1 : -1;
    endtask

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Idle percentage: sender light and receiver heavy, then swapped, then none.
    function automatic int idle_pct(input bit sender);
        if (n_accepted < stim_total / 3)
            return sender ? 26 : 51;
        if (n_accepted < (2 * stim_total) / 3)
            return sender ? 51 : 26;
        return 0;
    endfunction

    // Request driver: predicts each transfer and loads the next item when the slot is free.
    always @(posedge clk or negedge rst_n)
    begin
        bit acc;
        int in_flight;
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.operation <= '0;
            req_ch.value     <= '0;
            req_ch.position  <= '0;
            n_accepted       <= 0;
        end
        else
        begin
            acc = req_ch.valid && req_ch.ready;
            if (acc)
            begin
                expected_results.push_back(list_apply(cur_req));
                n_accepted <= n_accepted + 1;
            end
            in_flight = n_accepted + acc - n_results - (rsp_ch.valid && rsp_ch.ready);
            if (!req_ch.valid || acc)
            begin
                // A settle item waits until every earlier result has been transferred.
                if (pending_reqs.size() != 0
                    && !(pending_reqs[0].settle_first && in_flight != 0)
                    && $urandom_range(99) >= idle_pct(1'b1))
                begin
                    cur_req = pending_reqs.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.operation <= cur_req.op;
                    req_ch.value     <= cur_req.value;
                    req_ch.position  <= cur_req.position;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each transfer with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        list_outcome_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            n_results    <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_results <= n_results + 1;
                if (expected_results.size() == 0)
                begin
                    flag_error($sformatf({"result with none expected: ",
                                          "status %0d length %0d removed %0d"},
                                         rsp_ch.status, rsp_ch.length,
                                         rsp_ch.removed_value));
                end
                else
                begin
                    want = expected_results.pop_front();
                    status_hits[want.status]++;
                    if (rsp_ch.status !== want.status || rsp_ch.length !== want.length
                        || rsp_ch.removed_value !== want.removed)
                    begin
                        flag_error($sformatf({"expected status %0d length %0d removed %0d, ",
                                              "got status %0d length %0d removed %0d"},
                                             want.status, want.length, want.removed,
                                             rsp_ch.status, rsp_ch.length,
                                             rsp_ch.removed_value));
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int ins_pct;
        int hi;
        int r;
        logic [OP_W-1:0] op;
        logic [POS_W-1:0] pos;
        logic signed [DATA_W-1:0] v;

        // Deletes on an empty list, including one with a bad position.
        queue_request(OP_DEL_FRONT, 32'sd0, 10'd0, 1'b0);
        queue_request(OP_DEL_END, 32'sd0, 10'd0, 1'b0);
        queue_request(OP_DEL_POS, 32'sd0, 10'd0, 1'b0);
        // Insert positions outside the valid span, and the spare codes.
        queue_request(OP_INS_POS, 32'sd5, 10'd0, 1'b0);
        queue_request(OP_INS_POS, 32'sd5, 10'd2, 1'b0);
        queue_request(OP_SPARE_A, 32'sd1, 10'd1, 1'b0);
        queue_request(OP_SPARE_B, 32'sd1, 10'd1, 1'b0);
        // Build a short list with extreme values at every kind of position.
        queue_request(OP_INS_FRONT, 32'sh8000_0000, 10'd0, 1'b0);
        queue_request(OP_INS_END, 32'sh7FFF_FFFF, 10'd1023, 1'b0);
        queue_request(OP_INS_POS, -32'sd1, 10'd2, 1'b0);
        queue_request(OP_INS_POS, 32'sd0, 10'd4, 1'b0);
        queue_request(OP_INS_POS, -32'sd1, 10'd1023, 1'b0);
        queue_request(OP_INS_POS, 32'sh5555_5555, 10'd1, 1'b0);
        // Delete positions just outside the list, then drain it every way.
        queue_request(OP_DEL_POS, 32'sd0, 10'd0, 1'b0);
        queue_request(OP_DEL_POS, 32'sd0, 10'd6, 1'b0);
        queue_request(OP_DEL_POS, 32'sd0, 10'd5, 1'b0);
        queue_request(OP_DEL_POS, 32'sd0, 10'd2, 1'b0);
        queue_request(OP_DEL_END, 32'sd0, 10'd0, 1'b0);
        queue_request(OP_DEL_FRONT, 32'sd0, 10'd1023, 1'b0);
        queue_request(OP_DEL_POS, 32'sd0, 10'd1, 1'b0);
        queue_request(OP_INS_END, 32'shAAAA_AAAA, 10'd0, 1'b0);
        queue_request(OP_DEL_POS, 32'sd0, 10'd1023, 1'b0);

        // Random part: fill, drain and mixed phases so the list swings between empty and full.
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            case ((i / 120) % 3)
                0:       ins_pct = 90;
                1:       ins_pct = 10;
                default: ins_pct = 50;
            endcase
            r = $urandom_range(99);
            if (r < 3)
                op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
            else if ($urandom_range(99) < ins_pct)
            begin
                case ($urandom_range(2))
                    0:       op = OP_INS_FRONT;
                    1:       op = OP_INS_END;
                    default: op = OP_INS_POS;
                endcase
            end
            else
            begin
                case ($urandom_range(2))
                    0:       op = OP_DEL_FRONT;
                    1:       op = OP_DEL_END;
                    default: op = OP_DEL_POS;
                endcase
            end

            // Mostly valid positions, with some just past the end, zero, or anywhere.
            hi = is_insert(op) ? gen_len + 1 : (gen_len == 0 ? 1 : gen_len);
            r = $urandom_range(99);
            if (r < 85)
                pos = POS_W'($urandom_range(hi, 1));
            else if (r < 90)
                pos = POS_W'(hi + 1);
            else if (r < 93)
                pos = '0;
            else
                pos = POS_W'($urandom_range(1023, 0));

            case ($urandom_range(19))
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7FFF_FFFF;
                2:       v = 32'sd0;
                3:       v = -32'sd1;
                default: v = $urandom;
            endcase
            queue_request(op, v, pos, i == 0 || i == RANDOM_REQS / 2);
        end
        stim_total = pending_reqs.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last request transfer, then for every result.
        while (pending_reqs.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (n_results != n_accepted)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (expected_results.size() != 0)
            flag_error($sformatf("%0d expected results never arrived", expected_results.size()));

        $display("Covered %0d requests and %0d results, peak length %0d of %0d.",
                 n_accepted, n_results, peak_len, LIST_DEPTH);
        $display("Statuses seen: %0d done, %0d empty, %0d out of range, %0d full; %0d errors.",
                 status_hits[ST_DONE], status_hits[ST_EMPTY], status_hits[ST_RANGE],
                 status_hits[ST_FULL], n_errors);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
